// File: design/sha_pkg.sv
// sha-256 hash unit: shared types, constants and round functions
// no dependencies
package sha_pkg;

  localparam logic [1:0] OP_ABSORB  = 2'd0;
  localparam logic [1:0] OP_DIGEST  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic word_t rotr(word_t v, int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t sig0(word_t v);
    sig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t sig1(word_t v);
    sig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

  function automatic word_t bsig0(word_t v);
    bsig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t bsig1(word_t v);
    bsig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

endpackage

// File: design/sha_fifo.sv
// sha-256 hash unit: short command queue between front and back
// depends on sha_pkg
module sha_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  sha_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output sha_pkg::cmd_t rd_data
);
  import sha_pkg::*;

  cmd_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign wr_ready = cnt_r != 3'd4;
  assign rd_valid = cnt_r != 3'd0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) begin
        wp_r <= wp_r + 2'd1;
      end
      if (rd_valid && rd_ready) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + {2'd0, wr_valid && wr_ready} - {2'd0, rd_valid && rd_ready};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wp_r] <= wr_data;
    end
  end
endmodule

// File: design/sha_front.sv
// sha-256 hash unit: input front, drops unused op codes
// depends on sha_pkg
module sha_front (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    in_op,
  input  logic [7:0]    in_byte,
  output logic          q_valid,
  input  logic          q_ready,
  output sha_pkg::cmd_t q_data
);
  import sha_pkg::*;

  logic used;
  assign used      = (in_op == OP_ABSORB) || (in_op == OP_DIGEST) || (in_op == OP_RESTART);
  assign in_tready = q_ready;
  assign q_valid   = in_tvalid && used;
  assign q_data    = '{op: in_op, data_byte: in_byte};
endmodule

// File: design/sha_core.sv
// sha-256 hash unit: block buffer, round engine, padding and digest output
// depends on sha_pkg
module sha_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  sha_pkg::cmd_t q_data,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_word,
  output logic [2:0]    out_index,
  output logic          out_last
);
  import sha_pkg::*;

  state_t      st_r, st_nxt;
  word_t       blkw_r [16];
  word_t       w_r [16];
  word_t       h_r [8];
  word_t       hv_r [8];
  word_t       v_r [8];
  logic [5:0]  fill_r;
  logic [60:0] cnt_r;
  logic [5:0]  rnd_r;
  logic        dig_r;
  logic        pad2_r;
  logic [2:0]  oidx_r;
  logic        ovalid_r;
  word_t       oword_r;

  word_t t1, t2, wnew;
  word_t pw [16];
  logic [63:0] bits;
  logic [4:0]  lane_sh;

  assign bits  = {cnt_r, 3'b000};
  assign lane_sh = {~fill_r[1:0], 3'b000};
  assign q_ready = (st_r == ST_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_word   = oword_r;
  assign out_index  = oidx_r;
  assign out_last   = oidx_r == 3'd7;

  assign t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + ROUND_K[rnd_r] + w_r[0];
  assign t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign wnew = sig1(w_r[14]) + w_r[9] + sig0(w_r[1]) + w_r[0];

  // padded block words; second block when pad2 holds only zeros and length
  always_comb begin
    logic [7:0] b;
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (pad2_r) begin
          b = 8'h00;
        end else if (6'(4 * i + j) < fill_r) begin
          b = blkw_r[i][31 - 8 * j -: 8];
        end else if (6'(4 * i + j) == fill_r) begin
          b = 8'h80;
        end else begin
          b = 8'h00;
        end
        pw[i][31 - 8 * j -: 8] = b;
      end
    end
    if (pad2_r || fill_r < 6'd56) begin
      pw[14] = bits[63:32];
      pw[15] = bits[31:0];
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (q_valid && q_ready) begin
          if (q_data.op == OP_DIGEST) begin
            st_nxt = ST_PAD;
          end else if (q_data.op == OP_ABSORB && fill_r == 6'd63) begin
            st_nxt = ST_ROUND;
          end
        end
      end
      ST_PAD:   st_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 6'd63) st_nxt = ST_FOLD;
      ST_FOLD: begin
        if (!dig_r) begin
          st_nxt = ST_IDLE;
        end else if (!pad2_r && fill_r >= 6'd56) begin
          st_nxt = ST_PAD;
        end else begin
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: if (ovalid_r && out_tready && oidx_r == 3'd7) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      fill_r   <= '0;
      cnt_r    <= '0;
      dig_r    <= 1'b0;
      pad2_r   <= 1'b0;
      ovalid_r <= 1'b0;
      oidx_r   <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= H_INIT[i];
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: begin
          if (q_valid && q_ready) begin
            if (q_data.op == OP_ABSORB) begin
              blkw_r[fill_r[5:2]][lane_sh +: 8] <= q_data.data_byte;
              fill_r <= fill_r + 6'd1;
              cnt_r  <= cnt_r + 61'd1;
              dig_r  <= 1'b0;
              rnd_r  <= '0;
              for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
              for (int i = 0; i < 15; i++) w_r[i] <= blkw_r[i];
              w_r[15] <= {blkw_r[15][31:8], q_data.data_byte};
            end else if (q_data.op == OP_DIGEST) begin
              dig_r  <= 1'b1;
              pad2_r <= 1'b0;
              for (int i = 0; i < 8; i++) hv_r[i] <= h_r[i];
            end else begin
              fill_r <= '0;
              cnt_r  <= '0;
              for (int i = 0; i < 8; i++) h_r[i] <= H_INIT[i];
            end
          end
        end
        ST_PAD: begin
          rnd_r <= '0;
          for (int i = 0; i < 8; i++) v_r[i] <= hv_r[i];
          for (int i = 0; i < 16; i++) w_r[i] <= pw[i];
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
          w_r[15] <= wnew;
          v_r[0] <= t1 + t2;
          v_r[1] <= v_r[0];
          v_r[2] <= v_r[1];
          v_r[3] <= v_r[2];
          v_r[4] <= v_r[3] + t1;
          v_r[5] <= v_r[4];
          v_r[6] <= v_r[5];
          v_r[7] <= v_r[6];
          rnd_r  <= rnd_r + 6'd1;
        end
        ST_FOLD: begin
          if (dig_r) begin
            for (int i = 0; i < 8; i++) hv_r[i] <= hv_r[i] + v_r[i];
            pad2_r <= 1'b1;
            if (pad2_r || fill_r < 6'd56) begin
              ovalid_r <= 1'b1;
              oidx_r   <= '0;
              oword_r  <= hv_r[0] + v_r[0];
            end
          end else begin
            for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          end
        end
        ST_EMIT: begin
          if (ovalid_r && out_tready) begin
            if (oidx_r == 3'd7) begin
              ovalid_r <= 1'b0;
            end else begin
              oidx_r  <= oidx_r + 3'd1;
              oword_r <= hv_r[oidx_r + 3'd1];
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: design/sha256_hash_unit.sv
// sha-256 hash unit top level: front, command queue, compression core
// absorb: bytes are taken while the core is idle; a full block then runs 64 rounds and a fold
// digest: one or two padded blocks (pad, 64 rounds, fold each), then 8 output beats
// reset (rst_n low, synchronous) restores initial hash, clears counts
// depends on sha_pkg, sha_front, sha_fifo, sha_core
module sha256_hash_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32], zeros
  output logic        out_tlast   // last_word
);
  import sha_pkg::*;

  logic fv, fr, cv, cr;
  cmd_t fd, cd;
  logic [31:0] w;
  logic [2:0]  idx;

  sha_front u_front (
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_op(in_tuser), .in_byte(in_tdata),
    .q_valid(fv), .q_ready(fr), .q_data(fd));

  sha_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fv), .wr_ready(fr), .wr_data(fd),
    .rd_valid(cv), .rd_ready(cr), .rd_data(cd));

  sha_core u_core (
    .clk(clk), .rst_n(rst_n),
    .q_valid(cv), .q_ready(cr), .q_data(cd),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_word(w), .out_index(idx), .out_last(out_tlast));

  assign out_tdata = {5'd0, idx, w};
endmodule
